// ===== hdl/border_center_pixel_stats_top_assert.svh =====
// Assertion macros for the pixel statistics block.
// Both expect clk and arst_n in scope at the place of use.
`ifndef BORDER_CENTER_PIXEL_STATS_TOP_ASSERT_SVH
`define BORDER_CENTER_PIXEL_STATS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define BCPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bcps assertion failed");
`define BCPS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bcps forbidden condition");
`else
`define BCPS_ASSERT(lbl, prop)
`define BCPS_NEVER(lbl, expr)
`endif

`endif

// ===== hdl/bcps_pkg.sv =====
package bcps_pkg;

	localparam int POS_W     = 8;
	localparam int LEVEL_W   = 10;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PIXEL_BITS_DEF       = 10;
	localparam int SATURATION_LEVEL_DEF = 1023;
	localparam int OUTSIDE_LEVEL_DEF    = 1000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_A       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_B       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_START  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_END    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_LIMIT = 3'd7;

	// reset values
	localparam logic [POS_W-1:0]   RST_FRAME_SIZE    = 8'd216;
	localparam logic [POS_W-1:0]   RST_BORDER_LOW    = 8'd36;
	localparam logic [POS_W-1:0]   RST_BORDER_HIGH   = 8'd180;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_A       = 10'd400;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_B       = 10'd500;
	localparam logic [POS_W-1:0]   RST_CENTER_START  = 8'd98;
	localparam logic [POS_W-1:0]   RST_CENTER_END    = 8'd117;
	localparam logic [CNT_W-1:0]   RST_OUTSIDE_LIMIT = 16'd100;

	typedef struct packed {
		logic [POS_W-1:0]   frame_size;
		logic [POS_W-1:0]   border_low;
		logic [POS_W-1:0]   border_high;
		logic [LEVEL_W-1:0] level_a;
		logic [LEVEL_W-1:0] level_b;
		logic [POS_W-1:0]   center_start;
		logic [POS_W-1:0]   center_end;
		logic [CNT_W-1:0]   outside_limit;
	} cfg_t;

	typedef struct packed {
		logic in_border;
		logic in_center;
		logic frame_end;
	} region_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ===== hdl/border_center_pixel_stats_top.sv =====
// Square-frame pixel statistics. Pixels stream in raster order, one per cycle
// at full rate; the block tracks row and column itself and emits one result per
// frame on its last pixel: border counts above level A and level B, the count
// of saturated pixels in the center window, and a flag set when more pixels
// outside the window reached the outside level than outside_limit. result_valid
// is registered, set when the last pixel moves from s1 into the accumulators.
// The input only stalls when a frame-end pixel reaches the accumulators while
// the previous result is still unread. Registers take effect on the next pixel
// and should be written between pixels, not while a result is outstanding.
module border_center_pixel_stats_top
	import bcps_pkg::*;
#(
	parameter int PIXEL_BITS       = PIXEL_BITS_DEF,
	parameter int SATURATION_LEVEL = SATURATION_LEVEL_DEF,
	parameter int OUTSIDE_LEVEL    = OUTSIDE_LEVEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [CNT_W-1:0]      border_count_a,
	output logic [CNT_W-1:0]      border_count_b,
	output logic [CNT_W-1:0]      center_saturated_count,
	output logic                  outside_bright_flag
);

	cfg_t                  cfg;
	logic                  advance;
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	region_t               region_s1;

	bcps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcps_pos #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.pixel_s1    (pixel_s1),
		.region_s1   (region_s1)
	);

	bcps_acc #(
		.PIXEL_BITS       (PIXEL_BITS),
		.SATURATION_LEVEL (SATURATION_LEVEL),
		.OUTSIDE_LEVEL    (OUTSIDE_LEVEL)
	) u_acc (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg                    (cfg),
		.valid_s1               (valid_s1),
		.pixel_s1               (pixel_s1),
		.region_s1              (region_s1),
		.advance                (advance),
		.result_valid           (result_valid),
		.result_ready           (result_ready),
		.border_count_a         (border_count_a),
		.border_count_b         (border_count_b),
		.center_saturated_count (center_saturated_count),
		.outside_bright_flag    (outside_bright_flag)
	);

`include "border_center_pixel_stats_top_assert.svh"

	// a frame end blocked by an unread result must hold off the input
	`BCPS_NEVER(a_stall_blocks_in, valid_s1 && region_s1.frame_end && result_valid && !result_ready && pixel_ready)
	// a frame-end transfer always raises the result
	`BCPS_ASSERT(a_frame_end_result, advance && region_s1.frame_end |=> result_valid)
	// ordinary pixels never wait
	`BCPS_ASSERT(a_no_idle_stall, valid_s1 && !region_s1.frame_end |-> advance)

endmodule

// ===== hdl/bcps_cfg.sv =====
module bcps_cfg
	import bcps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_size    <= RST_FRAME_SIZE;
			cfg_q.border_low    <= RST_BORDER_LOW;
			cfg_q.border_high   <= RST_BORDER_HIGH;
			cfg_q.level_a       <= RST_LEVEL_A;
			cfg_q.level_b       <= RST_LEVEL_B;
			cfg_q.center_start  <= RST_CENTER_START;
			cfg_q.center_end    <= RST_CENTER_END;
			cfg_q.outside_limit <= RST_OUTSIDE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_SIZE:    cfg_q.frame_size    <= cfg_data[POS_W-1:0];
				REG_BORDER_LOW:    cfg_q.border_low    <= cfg_data[POS_W-1:0];
				REG_BORDER_HIGH:   cfg_q.border_high   <= cfg_data[POS_W-1:0];
				REG_LEVEL_A:       cfg_q.level_a       <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_B:       cfg_q.level_b       <= cfg_data[LEVEL_W-1:0];
				REG_CENTER_START:  cfg_q.center_start  <= cfg_data[POS_W-1:0];
				REG_CENTER_END:    cfg_q.center_end    <= cfg_data[POS_W-1:0];
				REG_OUTSIDE_LIMIT: cfg_q.outside_limit <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bcps_pos.sv =====
module bcps_pos
	import bcps_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic                  advance,
	output logic                  valid_s1,
	output logic [PIXEL_BITS-1:0] pixel_s1,
	output region_t               region_s1
);

	logic [POS_W-1:0] col_q, row_q;
	logic [POS_W-1:0] last;
	logic             accept;
	region_t          region;
	logic             row_end;
	logic             valid_q;

	assign last    = cfg.frame_size - POS_W'(1);
	assign row_end = col_q >= last;

	always_comb begin
		region.in_border = (col_q < cfg.border_low) || (col_q > cfg.border_high) ||
		                   (row_q < cfg.border_low) || (row_q > cfg.border_high);
		region.in_center = (row_q >= cfg.center_start) && (row_q <= cfg.center_end) &&
		                   (col_q >= cfg.center_start) && (col_q <= cfg.center_end);
		region.frame_end = row_end && (row_q >= last);
	end

	assign pixel_ready = !valid_q || advance;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pixel_ready)
				valid_q <= pixel_valid;
			if (accept) begin
				if (region.frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= pixel;
			region_s1 <= region;
		end
	end

	assign valid_s1 = valid_q;

endmodule

// ===== hdl/bcps_acc.sv =====
module bcps_acc
	import bcps_pkg::*;
#(
	parameter int PIXEL_BITS       = PIXEL_BITS_DEF,
	parameter int SATURATION_LEVEL = SATURATION_LEVEL_DEF,
	parameter int OUTSIDE_LEVEL    = OUTSIDE_LEVEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  valid_s1,
	input  logic [PIXEL_BITS-1:0] pixel_s1,
	input  region_t               region_s1,
	output logic                  advance,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [CNT_W-1:0]      border_count_a,
	output logic [CNT_W-1:0]      border_count_b,
	output logic [CNT_W-1:0]      center_saturated_count,
	output logic                  outside_bright_flag
);

	localparam int CMP_W = (PIXEL_BITS > LEVEL_W) ? PIXEL_BITS : LEVEL_W;
	localparam logic [CMP_W-1:0] SAT_LVL = CMP_W'(SATURATION_LEVEL);
	localparam logic [CMP_W-1:0] OUT_LVL = CMP_W'(OUTSIDE_LEVEL);

	logic [CMP_W-1:0] px;
	logic [CNT_W-1:0] a_q, b_q, sat_q, out_q;
	logic [CNT_W-1:0] a_nxt, b_nxt, sat_nxt, out_nxt;
	logic             result_valid_q;

	assign px = CMP_W'(pixel_s1);

	// only a frame-end pixel needs room in the result register
	assign advance = valid_s1 &&
	                 (!region_s1.frame_end || !result_valid_q || result_ready);

	always_comb begin
		a_nxt   = a_q;
		b_nxt   = b_q;
		sat_nxt = sat_q;
		out_nxt = out_q;
		if (region_s1.in_border) begin
			if (px > CMP_W'(cfg.level_a))
				a_nxt = sat_inc(a_q);
			if (px > CMP_W'(cfg.level_b))
				b_nxt = sat_inc(b_q);
		end
		if (region_s1.in_center) begin
			if (px >= SAT_LVL)
				sat_nxt = sat_inc(sat_q);
		end else if (px >= OUT_LVL) begin
			out_nxt = sat_inc(out_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q            <= '0;
			b_q            <= '0;
			sat_q          <= '0;
			out_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready)
				result_valid_q <= 1'b0;
			if (advance) begin
				if (region_s1.frame_end) begin
					a_q            <= '0;
					b_q            <= '0;
					sat_q          <= '0;
					out_q          <= '0;
					result_valid_q <= 1'b1;
				end else begin
					a_q   <= a_nxt;
					b_q   <= b_nxt;
					sat_q <= sat_nxt;
					out_q <= out_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && region_s1.frame_end) begin
			border_count_a         <= a_nxt;
			border_count_b         <= b_nxt;
			center_saturated_count <= sat_nxt;
			outside_bright_flag    <= out_nxt > cfg.outside_limit;
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ===== sim/border_center_pixel_stats_checker.sv =====
module border_center_pixel_stats_checker
	import bcps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	input  logic                  pixel_ready,
	input  logic [LEVEL_W-1:0]    pixel,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [CNT_W-1:0]      border_count_a,
	input  logic [CNT_W-1:0]      border_count_b,
	input  logic [CNT_W-1:0]      center_saturated_count,
	input  logic                  outside_bright_flag,
	output int                    mismatches,
	output int                    frames_due
);

	typedef struct packed {
		logic [CNT_W-1:0] count_a;
		logic [CNT_W-1:0] count_b;
		logic [CNT_W-1:0] sat_count;
		logic             bright;
	} frame_totals_t;

	frame_totals_t frame_totals_q[$];

	cfg_t             regs;
	logic [POS_W-1:0] col_pos;
	logic [POS_W-1:0] row_pos;
	logic [CNT_W-1:0] tally_a;
	logic [CNT_W-1:0] tally_b;
	logic [CNT_W-1:0] tally_sat;
	logic [CNT_W-1:0] tally_bright;

	// counters stick at all ones
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return c + CNT_W'(c != '1);
	endfunction

	task automatic clear_frame();
		col_pos = '0;
		row_pos = '0;
		tally_a = '0;
		tally_b = '0;
		tally_sat = '0;
		tally_bright = '0;
	endtask

	task automatic tally_pixel(input logic [LEVEL_W-1:0] px);
		logic [POS_W-1:0] last;
		logic             border;
		logic             center;
		logic             row_end;
		// frame size 0 wraps to a last position of 255
		last = regs.frame_size - 1'b1;
		border = (col_pos < regs.border_low) || (col_pos > regs.border_high) ||
			(row_pos < regs.border_low) || (row_pos > regs.border_high);
		center = (row_pos >= regs.center_start) && (row_pos <= regs.center_end) &&
			(col_pos >= regs.center_start) && (col_pos <= regs.center_end);
		row_end = col_pos >= last;
		if (border) begin
			if (px > regs.level_a)
				tally_a = bump(tally_a);
			if (px > regs.level_b)
				tally_b = bump(tally_b);
		end
		if (center) begin
			if (px >= SATURATION_LEVEL_DEF)
				tally_sat = bump(tally_sat);
		end else if (px >= OUTSIDE_LEVEL_DEF) begin
			tally_bright = bump(tally_bright);
		end
		if (row_end && row_pos >= last) begin
			frame_totals_q.push_back(frame_totals_t'{tally_a, tally_b, tally_sat,
				tally_bright > regs.outside_limit});
			clear_frame();
		end else if (row_end) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	task automatic check_result();
		frame_totals_t want;
		frame_totals_t got;
		got = frame_totals_t'{border_count_a, border_count_b, center_saturated_count,
			outside_bright_flag};
		if (frame_totals_q.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result transfer with no frame pending: a=%0d b=%0d sat=%0d flag=%0b",
					$realtime, got.count_a, got.count_b, got.sat_count, got.bright);
			mismatches++;
		end else begin
			want = frame_totals_q.pop_front();
			if (got.count_a !== want.count_a || got.count_b !== want.count_b ||
					got.sat_count !== want.sat_count || got.bright !== want.bright) begin
				if (mismatches < 10)
					$display("%0t: frame result mismatch: exp a=%0d b=%0d sat=%0d flag=%0b, got a=%0d b=%0d sat=%0d flag=%0b",
						$realtime, want.count_a, want.count_b, want.sat_count, want.bright,
						got.count_a, got.count_b, got.sat_count, got.bright);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = cfg_t'{RST_FRAME_SIZE, RST_BORDER_LOW, RST_BORDER_HIGH, RST_LEVEL_A,
				RST_LEVEL_B, RST_CENTER_START, RST_CENTER_END, RST_OUTSIDE_LIMIT};
			clear_frame();
			frame_totals_q.delete();
			mismatches = 0;
			frames_due = 0;
		end else begin
			// pop before push so a stray result is never matched to a fresh frame
			if (result_valid && result_ready)
				check_result();
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_SIZE:    regs.frame_size = cfg_data[POS_W-1:0];
					REG_BORDER_LOW:    regs.border_low = cfg_data[POS_W-1:0];
					REG_BORDER_HIGH:   regs.border_high = cfg_data[POS_W-1:0];
					REG_LEVEL_A:       regs.level_a = cfg_data[LEVEL_W-1:0];
					REG_LEVEL_B:       regs.level_b = cfg_data[LEVEL_W-1:0];
					REG_CENTER_START:  regs.center_start = cfg_data[POS_W-1:0];
					REG_CENTER_END:    regs.center_end = cfg_data[POS_W-1:0];
					REG_OUTSIDE_LIMIT: regs.outside_limit = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (pixel_valid && pixel_ready)
				tally_pixel(pixel);
			frames_due = frame_totals_q.size();
		end
	end

endmodule

// ===== sim/tb_border_center_pixel_stats_top.sv =====
module tb_border_center_pixel_stats_top;
	import bcps_pkg::*;

	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int QUIET_LIMIT    = 4000;
	localparam int PHASE_ITEMS    = 650;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pixel_valid = 1'b0;
	logic [LEVEL_W-1:0]    pixel = '0;
	logic                  result_ready = 1'b0;
	logic                  pixel_ready;
	logic                  result_valid;
	logic [CNT_W-1:0]      border_count_a;
	logic [CNT_W-1:0]      border_count_b;
	logic [CNT_W-1:0]      center_saturated_count;
	logic                  outside_bright_flag;

	int mismatches;
	int frames_due;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holdoff_asked = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	border_center_pixel_stats_top i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.pixel_valid            (pixel_valid),
		.pixel_ready            (pixel_ready),
		.pixel                  (pixel),
		.result_valid           (result_valid),
		.result_ready           (result_ready),
		.border_count_a         (border_count_a),
		.border_count_b         (border_count_b),
		.center_saturated_count (center_saturated_count),
		.outside_bright_flag    (outside_bright_flag)
	);

	border_center_pixel_stats_checker i_checker (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.pixel_valid            (pixel_valid),
		.pixel_ready            (pixel_ready),
		.pixel                  (pixel),
		.result_valid           (result_valid),
		.result_ready           (result_ready),
		.border_count_a         (border_count_a),
		.border_count_b         (border_count_b),
		.center_saturated_count (center_saturated_count),
		.outside_bright_flag    (outside_bright_flag),
		.mismatches             (mismatches),
		.frames_due             (frames_due)
	);

	// receiver: a requested hold-off wins over the random stalls
	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left = holdoff_left - 1;
			result_ready <= 1'b0;
		end else if (holdoff_served != holdoff_asked) begin
			holdoff_served = holdoff_served + 1;
			holdoff_left = HOLDOFF_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("border_center_pixel_stats_top regression: fail");
				$finish;
			end
		end
	end

	// entered and left right after a falling edge
	task automatic send_pixel(input logic [LEVEL_W-1:0] px);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		do
			@(posedge clk);
		while (!(pixel_valid && pixel_ready));
		@(negedge clk);
	endtask

	// no register write until every frame result has come back and the
	// pixel pipeline has gone quiet
	task automatic settle();
		pixel_valid <= 1'b0;
		@(negedge clk);
		while (frames_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input cfg_t s);
		logic [CFG_DATA_W-1:0] vals[8];
		logic [CFG_IDX_W-1:0]  idx[8];
		vals = '{CFG_DATA_W'(s.frame_size), CFG_DATA_W'(s.border_low),
			CFG_DATA_W'(s.border_high), CFG_DATA_W'(s.level_a), CFG_DATA_W'(s.level_b),
			CFG_DATA_W'(s.center_start), CFG_DATA_W'(s.center_end),
			CFG_DATA_W'(s.outside_limit)};
		idx = '{REG_FRAME_SIZE, REG_BORDER_LOW, REG_BORDER_HIGH, REG_LEVEL_A,
			REG_LEVEL_B, REG_CENTER_START, REG_CENTER_END, REG_OUTSIDE_LIMIT};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t make_settings(input logic [POS_W-1:0] fs,
		input logic [POS_W-1:0] bl, input logic [POS_W-1:0] bh,
		input logic [LEVEL_W-1:0] la, input logic [LEVEL_W-1:0] lb,
		input logic [POS_W-1:0] cs, input logic [POS_W-1:0] ce,
		input logic [CNT_W-1:0] lim);
		return cfg_t'{fs, bl, bh, la, lb, cs, ce, lim};
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return LEVEL_W'($urandom_range(990, 1023));
			1: return LEVEL_W'($urandom_range(0, 1023));
			2: return '1;
			default: return LEVEL_W'($urandom_range(0, 2));
		endcase
	endfunction

	// bias toward the outside and saturation levels where the counters move
	function automatic logic [LEVEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2, 3: return LEVEL_W'($urandom_range(995, 1023));
			default: return LEVEL_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic cfg_t pick_settings();
		cfg_t s;
		int   span;
		case ($urandom_range(0, 9))
			7, 8: s.frame_size = POS_W'($urandom_range(7, 16));
			9: s.frame_size = POS_W'($urandom_range(0, 255));
			default: s.frame_size = POS_W'($urandom_range(1, 6));
		endcase
		span = (s.frame_size == 0) ? 255 : s.frame_size;
		if ($urandom_range(0, 7) == 0) begin
			s.border_low = POS_W'($urandom_range(0, 255));
			s.border_high = POS_W'($urandom_range(0, 255));
			s.center_start = POS_W'($urandom_range(0, 255));
			s.center_end = POS_W'($urandom_range(0, 255));
		end else begin
			s.border_low = POS_W'($urandom_range(0, span));
			s.border_high = POS_W'($urandom_range(0, span));
			s.center_start = POS_W'($urandom_range(0, span));
			s.center_end = POS_W'($urandom_range(0, span));
		end
		s.level_a = pick_level();
		s.level_b = pick_level();
		case ($urandom_range(0, 3))
			0: s.outside_limit = '0;
			1: s.outside_limit = '1;
			2: s.outside_limit = CNT_W'($urandom_range(0, 6));
			default: s.outside_limit = CNT_W'($urandom_range(0, 65535));
		endcase
		return s;
	endfunction

	initial begin
		logic [LEVEL_W-1:0] band_px[9];
		cfg_t               s;
		int                 items_left;
		int                 burst;
		int                 epoch;
		band_px = '{10'd1023, 10'd1000, 10'd999, 10'd1023, 10'd0, 10'd1022, 10'd1023,
			10'd1001, 10'd512};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// start a frame at reset settings, then shrink the frame under it
		send_pixel(10'd0);
		send_pixel(10'd1023);
		send_pixel(10'd1000);
		settle();
		load_settings(make_settings(8'd2, 8'd1, 8'd0, 10'd0, 10'd1022, 8'd0, 8'd0, 16'd0));
		send_pixel(10'd1023);
		send_pixel(10'd1);
		send_pixel(10'd999);
		send_pixel(10'd0);
		send_pixel(10'd1023);
		send_pixel(10'd1000);
		send_pixel(10'd1022);

		// one-pixel frames, no border band
		settle();
		load_settings(make_settings(8'd1, 8'd0, 8'd255, 10'd1023, 10'd0, 8'd0, 8'd0, 16'hFFFF));
		send_pixel(10'd0);
		send_pixel(10'd1023);
		send_pixel(10'd1000);
		send_pixel(10'd999);
		send_pixel(10'd512);

		// all border, inverted center window
		settle();
		load_settings(make_settings(8'd3, 8'd255, 8'd255, 10'd1022, 10'd1023, 8'd2, 8'd1,
			16'd1));
		foreach (band_px[i])
			send_pixel(band_px[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			items_left = PHASE_ITEMS;
			epoch = 0;
			while (items_left > 0) begin
				settle();
				s = pick_settings();
				// one-pixel frames while the receiver holds off fill the block
				if (epoch == 0) begin
					s.frame_size = 8'd1;
					holdoff_asked = holdoff_asked + 1;
				end
				load_settings(s);
				burst = $urandom_range(20, 120);
				if (burst > items_left)
					burst = items_left;
				repeat (burst) send_pixel(pick_pixel());
				items_left -= burst;
				epoch++;
			end
		end

		settle();
		if (mismatches == 0 && frames_due == 0)
			$display("border_center_pixel_stats_top regression: pass");
		else
			$display("border_center_pixel_stats_top regression: fail");
		$finish;
	end

endmodule

// ===== border_center_pixel_stats_top.f =====
+incdir+hdl
hdl/bcps_pkg.sv
hdl/bcps_cfg.sv
hdl/bcps_pos.sv
hdl/bcps_acc.sv
hdl/border_center_pixel_stats_top.sv
sim/border_center_pixel_stats_checker.sv
sim/tb_border_center_pixel_stats_top.sv
